// ----- hdl/mbpuf_pkg.sv -----
// ---------------------------------------------------------------------------
// mbpuf_pkg: shared types and constants for the masked byte pattern finder
// Sizes, status and register codes, and the aligned pattern bundle.
// ---------------------------------------------------------------------------
package mbpuf_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int ADDR_BITS     = 48;
    localparam int REG_BYTES     = 16;   // pattern bytes held in the registers
    localparam int LEN_IN_BITS   = 5;
    localparam int LEN_BITS      = $clog2(PATTERN_BYTES + 1);
    localparam int REG_IDX_BITS  = $clog2(REG_BYTES);
    localparam int IDX_BITS      = (LEN_BITS > REG_IDX_BITS + 1) ? LEN_BITS : REG_IDX_BITS + 1;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 64;

    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_AMBIGUOUS = 2'd2,
        STATUS_EMPTY     = 2'd3
    } scan_status_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LOW  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_HIGH = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CARE_MASK    = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LEN  = 8'd3;

    // Pattern laid out per window slot, slot 0 being the newest byte.
    typedef struct packed {
        logic [PATTERN_BYTES-1:0][7:0] want;
        logic [PATTERN_BYTES-1:0]      care;
        logic [LEN_BITS-1:0]           len;
    } align_t;

endpackage

// ----- hdl/masked_byte_pattern_unique_finder.sv -----
// ---------------------------------------------------------------------------
// masked_byte_pattern_unique_finder: wildcard byte signature scanner
// Result path: after the transfer of its scan_last byte, the result of a scan
//   reaches m_valid through the input register, then the result register.
// Throughput: one byte per cycle; only a held result stalls a scan_last byte.
// Reset: synchronous, active low; clears registers, scan state and valids.
// The masked compare is one parallel pass over the 16-byte window.
// ---------------------------------------------------------------------------
module masked_byte_pattern_unique_finder (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mbpuf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mbpuf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // byte stream
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_data_byte,
    input  logic [mbpuf_pkg::ADDR_BITS-1:0]       s_byte_address,
    input  logic                                  s_section_last,
    input  logic                                  s_scan_last,
    // scan result
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mbpuf_pkg::ADDR_BITS-1:0]       m_match_address,
    output logic [1:0]                            m_scan_status
);

    localparam int PB = mbpuf_pkg::PATTERN_BYTES;
    localparam int AB = mbpuf_pkg::ADDR_BITS;
    localparam int LB = mbpuf_pkg::LEN_BITS;

    // ---------------- configuration registers ----------------
    logic [63:0]                       pat_low_reg;
    logic [63:0]                       pat_high_reg;
    logic [15:0]                       care_reg;
    logic [mbpuf_pkg::LEN_IN_BITS-1:0] len_reg;
    mbpuf_pkg::align_t                 align;

    assign cfg_ready = 1'b1;   // registers take a write every cycle

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            len_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mbpuf_pkg::CFG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                mbpuf_pkg::CFG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                mbpuf_pkg::CFG_CARE_MASK:    care_reg     <= cfg_data[15:0];
                mbpuf_pkg::CFG_PATTERN_LEN:  len_reg      <= cfg_data[mbpuf_pkg::LEN_IN_BITS-1:0];
                default: ;   // unmapped index: write dropped
            endcase
        end
    end

    // Pattern realigned to window slots by a register behind the configuration
    // registers; an item reaches the compare through the input register.
    mbpuf_pattern_align u_align (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .pattern_bytes_low  (pat_low_reg),
        .pattern_bytes_high (pat_high_reg),
        .care_mask          (care_reg),
        .pattern_length     (len_reg),
        .align              (align)
    );

    // ---------------- input register ----------------
    logic          s1_valid_reg;
    logic [7:0]    s1_data_reg;
    logic [AB-1:0] s1_addr_reg;
    logic          s1_sec_last_reg;
    logic          s1_scan_last_reg;
    logic          out_free;
    logic          s1_adv;

    logic          out_valid_reg;
    logic [AB-1:0] out_addr_reg;
    logic [1:0]    out_status_reg;

    // A scan_last byte only moves on when the result register can take it.
    assign out_free = !out_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && (!s1_scan_last_reg || out_free);
    assign s_ready  = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_data_reg      <= s_data_byte;
            s1_addr_reg      <= s_byte_address;
            s1_sec_last_reg  <= s_section_last;
            s1_scan_last_reg <= s_scan_last;
        end
    end

    // ---------------- scan state ----------------
    logic [PB-1:0][7:0] window_reg;
    logic [PB-1:0][7:0] window_next;
    logic [LB-1:0]      fill_reg;
    logic [LB-1:0]      fill_inc;
    logic [LB-1:0]      fill_next;
    logic [AB-1:0]      first_addr_reg;
    logic [AB-1:0]      first_addr_next;
    logic               seen_reg;
    logic               seen_next;
    logic               amb_reg;
    logic               amb_next;
    logic [PB-1:0]      slot_ok;
    logic               hit;
    logic [AB-1:0]      start_addr;
    logic [AB-1:0]      res_addr;
    logic [1:0]         res_status;

    // Window after this byte shifts in; slot 0 is the newest byte.
    always_comb begin
        window_next[0] = s1_data_reg;
        for (int j = 1; j < PB; j++) begin
            window_next[j] = window_reg[j-1];
        end
    end

    assign fill_inc = (int'(fill_reg) < PB) ? fill_reg + LB'(1) : fill_reg;

    always_comb begin
        for (int j = 0; j < PB; j++) begin
            slot_ok[j] = !align.care[j] || (window_next[j] == align.want[j]);
        end
    end

    // The section must hold at least len bytes; an empty pattern never hits.
    assign hit        = (align.len != '0) && (fill_inc >= align.len) && (&slot_ok);
    assign start_addr = s1_addr_reg - AB'(align.len) + AB'(1);

    always_comb begin
        seen_next       = seen_reg | hit;
        amb_next        = amb_reg | (hit & seen_reg);
        first_addr_next = seen_reg ? first_addr_reg : (hit ? start_addr : first_addr_reg);
        fill_next       = (s1_sec_last_reg || s1_scan_last_reg) ? '0 : fill_inc;

        priority if (align.len == '0) begin
            res_status = mbpuf_pkg::STATUS_EMPTY;
            res_addr   = '0;
        end else if (amb_next) begin
            res_status = mbpuf_pkg::STATUS_AMBIGUOUS;
            res_addr   = '0;
        end else if (seen_next) begin
            res_status = mbpuf_pkg::STATUS_FOUND;
            res_addr   = first_addr_next;
        end else begin
            res_status = mbpuf_pkg::STATUS_NOT_FOUND;
            res_addr   = '0;
        end
    end

    // Window content past fill is never looked at, so it needs no reset.
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            first_addr_reg <= '0;
            seen_reg       <= 1'b0;
            amb_reg        <= 1'b0;
        end else if (s1_adv) begin
            fill_reg <= fill_next;
            if (s1_scan_last_reg) begin
                // end of scan: start the next one clean
                first_addr_reg <= '0;
                seen_reg       <= 1'b0;
                amb_reg        <= 1'b0;
            end else begin
                first_addr_reg <= first_addr_next;
                seen_reg       <= seen_next;
                amb_reg        <= amb_next;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv && s1_scan_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_scan_last_reg) begin
            out_addr_reg   <= res_addr;
            out_status_reg <= res_status;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_match_address = out_addr_reg;
    assign m_scan_status   = out_status_reg;

`ifndef NO_ASSERTIONS
    a_addr_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_scan_status != mbpuf_pkg::STATUS_FOUND) |-> m_match_address == '0)
        else $error("match address nonzero without a unique match");

    a_amb_implies_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        amb_reg |-> seen_reg)
        else $error("ambiguous flag set without a first match");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= PB)
        else $error("section fill past window depth");

    a_scan_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && s1_scan_last_reg |=> !seen_reg && !amb_reg && (fill_reg == '0) && m_valid)
        else $error("scan state not cleared or result missing after scan end");
`endif

endmodule

// ----- hdl/mbpuf_pattern_align.sv -----
// ---------------------------------------------------------------------------
// mbpuf_pattern_align: maps the configured pattern onto window slots
// Registers the expected byte and care bit of every window slot, and the length.
// ---------------------------------------------------------------------------
module mbpuf_pattern_align (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [63:0]                          pattern_bytes_low,
    input  logic [63:0]                          pattern_bytes_high,
    input  logic [15:0]                          care_mask,
    input  logic [mbpuf_pkg::LEN_IN_BITS-1:0]    pattern_length,
    output mbpuf_pkg::align_t                    align
);

    mbpuf_pkg::align_t align_reg;
    mbpuf_pkg::align_t align_next;

    always_comb begin
        logic [mbpuf_pkg::REG_BYTES-1:0][7:0] pat;
        logic [mbpuf_pkg::LEN_BITS-1:0]       len_c;
        logic [mbpuf_pkg::IDX_BITS-1:0]       k;
        pat = {pattern_bytes_high, pattern_bytes_low};
        if (int'(pattern_length) > mbpuf_pkg::PATTERN_BYTES) begin
            len_c = mbpuf_pkg::LEN_BITS'(mbpuf_pkg::PATTERN_BYTES);
        end else begin
            len_c = mbpuf_pkg::LEN_BITS'(pattern_length);
        end
        align_next.len = len_c;
        for (int j = 0; j < mbpuf_pkg::PATTERN_BYTES; j++) begin
            // slot j holds pattern byte (len - 1 - j)
            k = mbpuf_pkg::IDX_BITS'(len_c) - mbpuf_pkg::IDX_BITS'(1)
                - mbpuf_pkg::IDX_BITS'(j);
            align_next.want[j] = 8'd0;
            align_next.care[j] = 1'b0;
            if (j < int'(len_c) && int'(k) < mbpuf_pkg::REG_BYTES) begin
                align_next.want[j] = pat[k[mbpuf_pkg::REG_IDX_BITS-1:0]];
                align_next.care[j] = care_mask[k[mbpuf_pkg::REG_IDX_BITS-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_reg <= '0;
        end else begin
            align_reg <= align_next;
        end
    end

    assign align = align_reg;

endmodule
